FILE: hdl/status_led_color_breathe_macros.svh
// Assertion macros for the status LED block.
// Each macro expects clk and rst_n in scope and ends its own statement.
`ifndef STATUS_LED_COLOR_BREATHE_MACROS_SVH
`define STATUS_LED_COLOR_BREATHE_MACROS_SVH

`ifndef SYNTHESIS
`define SLB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slb check failed");
`define SLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slb check failed");
`else
`define SLB_ASSERT_NOW(lbl, ante, cons)
`define SLB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/slb_pkg.sv
package slb_pkg;

  localparam int MAX_SESSIONS  = 8;
  localparam int PACKED_SLOTS  = 8;
  localparam int SESSION_LIMIT = (MAX_SESSIONS < PACKED_SLOTS) ? MAX_SESSIONS : PACKED_SLOTS;

  localparam int CNT_W      = 4;
  localparam int STATES_W   = 16;
  localparam int TIME_W     = 32;
  localparam int PER_W      = 16;
  localparam int CH_W       = 8;
  localparam int TRI_W      = 13;   // 0..4096
  localparam int SCALE_W    = 13;   // Q1.12, at most 4096
  localparam int AMP_W      = 12;
  localparam int PROD_W     = AMP_W + TRI_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MOD_STEPS  = TIME_W;      // one remainder bit per stage
  localparam int TRI_STEPS  = TRI_W - 1;   // top quotient bit is set in the fold stage

  localparam logic [PER_W-1:0] PULSE_RESET   = 16'd1000;
  localparam logic [PER_W-1:0] BREATHE_RESET = 16'd3200;

  localparam logic [1:0] SESS_WORKING = 2'd1;
  localparam logic [1:0] SESS_WAITING = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_ENABLE     = 2'd0,
    REG_PULSE_PERIOD   = 2'd1,
    REG_BREATHE_PERIOD = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ERROR = 3'd1,
    MODE_WARN  = 3'd2,
    MODE_WAIT  = 3'd3,
    MODE_WORK  = 3'd4,
    MODE_IDLE  = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic             short_per;
    logic [PER_W-1:0] period;
  } ctrl_t;

  typedef struct packed {
    logic [PER_W-1:0]  rem;
    logic [TIME_W-1:0] num;
    logic [TRI_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic drive;
    rgb_t rgb;
  } result_t;

  function automatic rgb_t mode_color(mode_t m);
    rgb_t c;
    case (m)
      MODE_ERROR: c = '{r: 8'd255, g: 8'd40,  b: 8'd40};
      MODE_WARN:  c = '{r: 8'd255, g: 8'd40,  b: 8'd40};
      MODE_WAIT:  c = '{r: 8'd46,  g: 8'd204, b: 8'd113};
      MODE_WORK:  c = '{r: 8'd255, g: 8'd159, b: 8'd28};
      MODE_IDLE:  c = '{r: 8'd40,  g: 8'd90,  b: 8'd160};
      default:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

  function automatic logic [SCALE_W-1:0] mode_base(mode_t m);
    logic [SCALE_W-1:0] v;
    case (m)
      MODE_ERROR: v = 13'd819;
      MODE_WARN:  v = 13'd3482;
      MODE_WAIT:  v = 13'd1024;
      MODE_WORK:  v = 13'd492;
      MODE_IDLE:  v = 13'd246;
      default:    v = 13'd0;
    endcase
    return v;
  endfunction

  function automatic logic [AMP_W-1:0] mode_amp(mode_t m);
    logic [AMP_W-1:0] v;
    case (m)
      MODE_ERROR: v = 12'd2458;
      MODE_WAIT:  v = 12'd3072;
      MODE_WORK:  v = 12'd1843;
      default:    v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/slb_chan_if.sv
interface slb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          link_up;
  logic                          host_error;
  logic                          near_limit;
  logic [slb_pkg::CNT_W-1:0]     session_count;
  logic [slb_pkg::STATES_W-1:0]  session_states;
  logic [slb_pkg::TIME_W-1:0]    now_ms;

  modport source (
    output valid, link_up, host_error, near_limit, session_count, session_states, now_ms,
    input  ready
  );
  modport sink (
    input  valid, link_up, host_error, near_limit, session_count, session_states, now_ms,
    output ready
  );
endinterface

interface slb_out_if;
  logic                     valid;
  logic                     ready;
  logic                     drive;
  logic [slb_pkg::CH_W-1:0] red;
  logic [slb_pkg::CH_W-1:0] green;
  logic [slb_pkg::CH_W-1:0] blue;

  modport source (
    output valid, drive, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, drive, red, green, blue,
    output ready
  );
endinterface

FILE: hdl/status_led_color_breathe.sv
// Status LED color selector. Each request on in_ch is one status snapshot;
// exactly one result leaves on out_ch for each, in order. Priority: no link
// or host error pulses red, near limit is steady red, a waiting session
// pulses green, a working session breathes amber, otherwise dim blue.
// Pulse brightness is base + amp * tri(now_ms mod period), Q1.12, and each
// channel is (color * scale) >> 12. With led_enable low the result has
// drive = 0 and all channels 0. Throughput is one request per clock while
// the output buffer is not full. Each request passes the front register,
// the phase divider (32 restoring stages, now_ms mod period), one fold
// stage, the triangle divider (12 restoring stages for the quotient),
// then three stages of scaling and finally the output register. A
// two-entry output buffer keeps in_ch.ready registered; the whole pipe
// holds while that buffer is full. Configuration writes take effect at
// once and are meant to be made while no request is in flight.
`include "status_led_color_breathe_macros.svh"

module status_led_color_breathe (
  input  logic                           clk,
  input  logic                           rst_n,
  slb_in_if.sink                         in_ch,
  slb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [slb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slb_pkg::*;

  // Configuration registers.
  logic             led_enable_r;
  logic [PER_W-1:0] pulse_period_r;
  logic [PER_W-1:0] breathe_period_r;

  // Global advance: the whole pipe moves unless the output buffer is full.
  logic             adv;

  // Phase divider chain: position 0 is the front register.
  logic             mod_v    [MOD_STEPS+1];
  ctrl_t            mod_ctrl [MOD_STEPS+1];
  div_t             mod_div  [MOD_STEPS+1];

  // Triangle divider chain: position 0 is the fold register.
  logic             tri_v    [TRI_STEPS+1];
  ctrl_t            tri_ctrl [TRI_STEPS+1];
  div_t             tri_div  [TRI_STEPS+1];

  logic             res_v;
  result_t          res;

  // Write the addressed register; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_enable_r     <= 1'b0;
      pulse_period_r   <= PULSE_RESET;
      breathe_period_r <= BREATHE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_ENABLE:     led_enable_r     <= cfg_data[0];
        REG_PULSE_PERIOD:   pulse_period_r   <= cfg_data[PER_W-1:0];
        REG_BREATHE_PERIOD: breathe_period_r <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the snapshot into a mode and pick the period.
  slb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .led_enable     (led_enable_r),
    .pulse_period   (pulse_period_r),
    .breathe_period (breathe_period_r),
    .in_ch          (in_ch),
    .v_out          (mod_v[0]),
    .ctrl_out       (mod_ctrl[0]),
    .div_out        (mod_div[0])
  );

  // now_ms mod period, one remainder bit per stage.
  for (genvar s = 0; s < MOD_STEPS; s++) begin : g_mod
    slb_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .v_in     (mod_v[s]),
      .ctrl_in  (mod_ctrl[s]),
      .div_in   (mod_div[s]),
      .v_out    (mod_v[s+1]),
      .ctrl_out (mod_ctrl[s+1]),
      .div_out  (mod_div[s+1])
    );
  end

  // Fold the phase into the triangle numerator and set the top quotient bit.
  slb_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .v_in     (mod_v[MOD_STEPS]),
    .ctrl_in  (mod_ctrl[MOD_STEPS]),
    .div_in   (mod_div[MOD_STEPS]),
    .v_out    (tri_v[0]),
    .ctrl_out (tri_ctrl[0]),
    .div_out  (tri_div[0])
  );

  // tri = d * 4096 / period, one quotient bit per stage.
  for (genvar s = 0; s < TRI_STEPS; s++) begin : g_tri
    slb_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .v_in     (tri_v[s]),
      .ctrl_in  (tri_ctrl[s]),
      .div_in   (tri_div[s]),
      .v_out    (tri_v[s+1]),
      .ctrl_out (tri_ctrl[s+1]),
      .div_out  (tri_div[s+1])
    );
  end

  // Brightness scale, then the three channel products.
  slb_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .v_in    (tri_v[TRI_STEPS]),
    .ctrl_in (tri_ctrl[TRI_STEPS]),
    .tri_in  (tri_div[TRI_STEPS].quo),
    .v_out   (res_v),
    .res_out (res)
  );

  // Output register plus one spare entry; its ready drives the pipe.
  slb_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_v),
    .up_data  (res),
    .up_ready (adv),
    .out_ch   (out_ch)
  );

  // A result that does not drive the LED carries no color.
  `SLB_ASSERT_NOW(a_off_is_dark, out_ch.valid && !out_ch.drive, out_ch.red == 8'd0 && out_ch.green == 8'd0 && out_ch.blue == 8'd0)
  // The spare entry only fills behind a waiting output.
  `SLB_ASSERT_NOW(a_spare_behind_out, !adv, out_ch.valid)
  // A taken output pulls the spare forward and frees the pipe.
  `SLB_ASSERT_NEXT(a_spare_drains, !adv && out_ch.ready, adv && out_ch.valid)
  // While the sink stalls, a full spare stays full.
  `SLB_ASSERT_NEXT(a_spare_holds, !adv && !out_ch.ready, !adv)

endmodule

FILE: hdl/slb_front.sv
module slb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      led_enable,
  input  logic [slb_pkg::PER_W-1:0] pulse_period,
  input  logic [slb_pkg::PER_W-1:0] breathe_period,
  slb_in_if.sink                    in_ch,
  output logic                      v_out,
  output slb_pkg::ctrl_t            ctrl_out,
  output slb_pkg::div_t             div_out
);
  import slb_pkg::*;

  logic             v_r;
  ctrl_t            ctrl_r;
  div_t             div_r;
  ctrl_t            ctrl_nxt;
  logic [CNT_W-1:0] cnt_sat;
  logic             waiting;
  logic             working;
  logic [1:0]       st;

  assign in_ch.ready = adv;

  always_comb begin
    cnt_sat = (in_ch.session_count > CNT_W'(SESSION_LIMIT)) ?
              CNT_W'(SESSION_LIMIT) : in_ch.session_count;
    waiting = 1'b0;
    working = 1'b0;
    st      = 2'd0;
    for (int i = 0; i < PACKED_SLOTS; i++) begin
      st = in_ch.session_states[2*i +: 2];
      if (CNT_W'(i) < cnt_sat) begin
        if (st == SESS_WAITING) waiting = 1'b1;
        if (st == SESS_WORKING) working = 1'b1;
      end
    end
  end

  always_comb begin
    if (!led_enable)                           ctrl_nxt.mode = MODE_OFF;
    else if (!in_ch.link_up || in_ch.host_error) ctrl_nxt.mode = MODE_ERROR;
    else if (in_ch.near_limit)                 ctrl_nxt.mode = MODE_WARN;
    else if (waiting)                          ctrl_nxt.mode = MODE_WAIT;
    else if (working)                          ctrl_nxt.mode = MODE_WORK;
    else                                       ctrl_nxt.mode = MODE_IDLE;
    ctrl_nxt.period    = (ctrl_nxt.mode == MODE_WORK) ? breathe_period : pulse_period;
    ctrl_nxt.short_per = (ctrl_nxt.period < 16'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r    <= ctrl_nxt;
      div_r.rem <= '0;
      div_r.num <= in_ch.now_ms;
      div_r.quo <= '0;
    end
  end

  assign v_out    = v_r;
  assign ctrl_out = ctrl_r;
  assign div_out  = div_r;

endmodule

FILE: hdl/slb_div_step.sv
module slb_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           v_in,
  input  slb_pkg::ctrl_t ctrl_in,
  input  slb_pkg::div_t  div_in,
  output logic           v_out,
  output slb_pkg::ctrl_t ctrl_out,
  output slb_pkg::div_t  div_out
);
  import slb_pkg::*;

  logic           v_r;
  ctrl_t          ctrl_r;
  div_t           div_r;
  div_t           div_nxt;
  logic [PER_W:0] trial;
  logic [PER_W:0] diff;
  logic           ge;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial         = {div_in.rem, div_in.num[TIME_W-1]};
    diff          = trial - {1'b0, ctrl_in.period};
    ge            = (trial >= {1'b0, ctrl_in.period});
    div_nxt.rem   = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
    div_nxt.num   = {div_in.num[TIME_W-2:0], 1'b0};
    div_nxt.quo   = {div_in.quo[TRI_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_in;
      div_r  <= div_nxt;
    end
  end

  assign v_out    = v_r;
  assign ctrl_out = ctrl_r;
  assign div_out  = div_r;

endmodule

FILE: hdl/slb_fold.sv
module slb_fold (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           v_in,
  input  slb_pkg::ctrl_t ctrl_in,
  input  slb_pkg::div_t  div_in,
  output logic           v_out,
  output slb_pkg::ctrl_t ctrl_out,
  output slb_pkg::div_t  div_out
);
  import slb_pkg::*;

  logic             v_r;
  ctrl_t            ctrl_r;
  div_t             div_r;
  div_t             div_nxt;
  logic [PER_W:0]   twice_p;
  logic [PER_W-1:0] back;
  logic [PER_W-1:0] d;
  logic             full;

  // Fold the phase into a triangle: rising on the first half, falling after.
  always_comb begin
    twice_p = {div_in.rem, 1'b0};
    back    = ctrl_in.period - div_in.rem;
    if (ctrl_in.short_per) begin
      d = '0;
    end else if (twice_p <= {1'b0, ctrl_in.period}) begin
      d = twice_p[PER_W-1:0];
    end else begin
      d = {back[PER_W-2:0], 1'b0};
    end
    full        = !ctrl_in.short_per && (d == ctrl_in.period);
    div_nxt.rem = full ? '0 : d;
    div_nxt.num = '0;
    div_nxt.quo = {{(TRI_W-1){1'b0}}, full};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_in;
      div_r  <= div_nxt;
    end
  end

  assign v_out    = v_r;
  assign ctrl_out = ctrl_r;
  assign div_out  = div_r;

endmodule

FILE: hdl/slb_scale.sv
module slb_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      v_in,
  input  slb_pkg::ctrl_t            ctrl_in,
  input  logic [slb_pkg::TRI_W-1:0] tri_in,
  output logic                      v_out,
  output slb_pkg::result_t          res_out
);
  import slb_pkg::*;

  logic [2:0]          v_r;
  mode_t               mode_a_r;
  mode_t               mode_b_r;
  logic [SCALE_W-1:0]  base_a_r;
  logic [PROD_W-1:0]   prod_a_r;
  logic [SCALE_W-1:0]  scale_b_r;
  result_t             res_r;
  logic [TRI_W-1:0]    tri_eff;
  logic [PROD_W-1:0]   prod_nxt;
  logic [SCALE_W:0]    sum;
  rgb_t                col;
  logic [CH_W+SCALE_W-1:0] pr;
  logic [CH_W+SCALE_W-1:0] pg;
  logic [CH_W+SCALE_W-1:0] pb;
  result_t             res_nxt;

  always_comb begin
    tri_eff  = ctrl_in.short_per ? '0 : tri_in;
    prod_nxt = {{TRI_W{1'b0}}, mode_amp(ctrl_in.mode)} * {{AMP_W{1'b0}}, tri_eff};
  end

  assign sum = {1'b0, base_a_r} + {1'b0, prod_a_r[PROD_W-1:12]};

  always_comb begin
    col             = mode_color(mode_b_r);
    pr              = {{SCALE_W{1'b0}}, col.r} * {{CH_W{1'b0}}, scale_b_r};
    pg              = {{SCALE_W{1'b0}}, col.g} * {{CH_W{1'b0}}, scale_b_r};
    pb              = {{SCALE_W{1'b0}}, col.b} * {{CH_W{1'b0}}, scale_b_r};
    res_nxt.drive   = (mode_b_r != MODE_OFF);
    res_nxt.rgb.r   = pr[12 +: CH_W];
    res_nxt.rgb.g   = pg[12 +: CH_W];
    res_nxt.rgb.b   = pb[12 +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_a_r  <= ctrl_in.mode;
      base_a_r  <= mode_base(ctrl_in.mode);
      prod_a_r  <= prod_nxt;
      mode_b_r  <= mode_a_r;
      scale_b_r <= sum[SCALE_W-1:0];
      res_r     <= res_nxt;
    end
  end

  assign v_out   = v_r[2];
  assign res_out = res_r;

endmodule

FILE: hdl/slb_skid.sv
module slb_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  slb_pkg::result_t up_data,
  output logic             up_ready,
  slb_out_if.source        out_ch
);
  import slb_pkg::*;

  logic    out_v_r;
  logic    skid_v_r;
  result_t out_d_r;
  result_t skid_d_r;
  logic    out_free;

  assign out_free = out_ch.ready || !out_v_r;
  assign up_ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || up_valid;
      skid_v_r <= 1'b0;
    end else if (up_valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : up_data;
    end
    if (!skid_v_r && !out_free) begin
      skid_d_r <= up_data;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.drive = out_d_r.drive;
  assign out_ch.red   = out_d_r.rgb.r;
  assign out_ch.green = out_d_r.rgb.g;
  assign out_ch.blue  = out_d_r.rgb.b;

endmodule
